// ===== sv/btm_pkg.sv =====
// ----------------------------------------------------------------------------
// btm_pkg
// shared constants, codes and types of the binary trie maximum xor multiset
// ----------------------------------------------------------------------------
package btm_pkg;

   localparam int KEY_BITS   = 31;
   localparam int NODE_COUNT = 8192;
   localparam int COUNT_BITS = 16;

   localparam int VALUE_W  = 31;
   localparam int ANSWER_W = 31;
   localparam int PTR_W    = $clog2(NODE_COUNT);
   localparam int FREE_W   = $clog2(NODE_COUNT + 1);
   localparam int LVL_W    = $clog2(KEY_BITS + 1);
   localparam int IDX_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
   localparam logic [1:0] STATUS_ABSENT  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   typedef struct packed {
      logic [PTR_W-1:0]      link1;
      logic [PTR_W-1:0]      link0;
      logic [COUNT_BITS-1:0] cnt;
   } node_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      node_type         wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_INS_WALK,
      ST_INS_NEW,
      ST_ERS_CHECK,
      ST_ERS_ROOT,
      ST_ERS_DEC,
      ST_QRY_PICK,
      ST_QRY_OPP,
      ST_QRY_SAME,
      ST_FINISH
   } state_type;

endpackage

// ===== sv/binary_trie_max_xor_multiset.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor_multiset
// multiset of 31-bit keys in a binary trie with a maximum xor query
// ----------------------------------------------------------------------------
// usage
//   req channel: op (insert, erase one copy, query) and value; a transaction
//   is taken when req_valid is high and req_stall is low. req_stall is high
//   while a transaction is being worked on, one transaction at a time.
//   rsp channel: one answer and status per request transaction, held in an
//   output register until taken; a new request is taken while it waits.
//   per transaction: insert makes one node memory access per trie level,
//   erase runs a presence walk and then a decrement walk, query makes
//   up to two node reads per level; rejected, empty and unknown-op
//   transactions go straight from the start state to the finish state.
//   the node memory read is registered, so each walk waits on it per level.
//   reset: root links null, node pool starts at slot 1, member total zero,
//   no response pending; the node memory itself is not cleared.
//   a stalled rsp keeps its payload; a finished transaction waits in its
//   last state until the output register frees up.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_multiset (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [btm_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [btm_pkg::ANSWER_W-1:0]  rsp_answer,
   output logic [1:0]                    rsp_status
);
   import btm_pkg::*;

   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [LVL_W-1:0]      rem_ff, rem_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [FREE_W-1:0]     free_ff, free_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [PTR_W-1:0]      root0_ff, root0_in;
   logic [PTR_W-1:0]      root1_ff, root1_in;
   logic [PTR_W-1:0]      ql0_ff, ql0_in;
   logic [PTR_W-1:0]      ql1_ff, ql1_in;
   logic [ANSWER_W-1:0]   ans_ff, ans_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ANSWER_W-1:0]   rsp_answer_ff, rsp_answer_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   mem_req_type           mem_req;
   node_type              rd_data;

   logic [IDX_W-1:0]      pick_idx;
   logic                  pick_bit;
   logic                  leaf;
   logic [PTR_W-1:0]      root_child;
   logic [PTR_W-1:0]      node_child;
   logic [PTR_W-1:0]      q_opp;
   logic [PTR_W-1:0]      q_same;
   logic [PTR_W-1:0]      free_ptr;
   logic                  no_room;
   logic                  out_free;

   btm_node_mem u_node_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign pick_idx   = IDX_W'(rem_ff - 1'b1);
   assign pick_bit   = value_ff[pick_idx];
   assign leaf       = (rem_ff == '0);
   assign root_child = pick_bit ? root1_ff : root0_ff;
   assign node_child = pick_bit ? rd_data.link1 : rd_data.link0;
   assign q_opp      = pick_bit ? ql0_ff : ql1_ff;
   assign q_same     = pick_bit ? ql1_ff : ql0_ff;
   assign free_ptr   = free_ff[PTR_W-1:0];
   assign no_room    = (({1'b0, free_ff} + (FREE_W+1)'(KEY_BITS)) > (FREE_W+1)'(NODE_COUNT))
                       || (total_ff == '1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            case (op_ff)
               OP_INSERT: begin
                  if (no_room)                 state_in = ST_FINISH;
                  else if (root_child == '0)   state_in = ST_INS_NEW;
                  else                         state_in = ST_INS_WALK;
               end
               OP_ERASE: begin
                  if (root_child == '0) state_in = ST_FINISH;
                  else                  state_in = ST_ERS_CHECK;
               end
               OP_QUERY: begin
                  if (total_ff == '0) state_in = ST_FINISH;
                  else                state_in = ST_QRY_PICK;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_INS_WALK: begin
            if (leaf)                    state_in = ST_FINISH;
            else if (node_child == '0)   state_in = ST_INS_NEW;
         end
         ST_INS_NEW: begin
            if (leaf) state_in = ST_FINISH;
         end
         ST_ERS_CHECK: begin
            if (rd_data.cnt == '0 || (!leaf && node_child == '0)) state_in = ST_FINISH;
            else if (leaf)                                        state_in = ST_ERS_ROOT;
         end
         ST_ERS_ROOT: begin
            state_in = ST_ERS_DEC;
         end
         ST_ERS_DEC: begin
            if (leaf) state_in = ST_FINISH;
         end
         ST_QRY_PICK: begin
            if (leaf)                state_in = ST_FINISH;
            else if (q_opp != '0)    state_in = ST_QRY_OPP;
            else if (q_same != '0)   state_in = ST_QRY_SAME;
         end
         ST_QRY_OPP: begin
            if (rd_data.cnt != '0)   state_in = ST_QRY_PICK;
            else if (q_same != '0)   state_in = ST_QRY_SAME;
            else                     state_in = ST_QRY_PICK;
         end
         ST_QRY_SAME: begin
            state_in = ST_QRY_PICK;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory requests
   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      rem_in        = rem_ff;
      ptr_in        = ptr_ff;
      free_in       = free_ff;
      total_in      = total_ff;
      root0_in      = root0_ff;
      root1_in      = root1_ff;
      ql0_in        = ql0_ff;
      ql1_in        = ql1_ff;
      ans_in        = ans_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_status_in = rsp_status_ff;
      mem_req       = '0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               value_in  = req_value;
               rem_in    = LVL_W'(KEY_BITS);
               ans_in    = '0;
               status_in = STATUS_OK;
            end
         end
         ST_START: begin
            case (op_ff)
               OP_INSERT: begin
                  if (no_room) begin
                     status_in = STATUS_NO_ROOM;
                  end else begin
                     rem_in = rem_ff - 1'b1;
                     if (root_child == '0) begin
                        if (pick_bit) root1_in = free_ptr;
                        else          root0_in = free_ptr;
                        ptr_in  = free_ptr;
                        free_in = free_ff + 1'b1;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = root_child;
                        ptr_in          = root_child;
                     end
                  end
               end
               OP_ERASE: begin
                  if (root_child == '0) begin
                     status_in = STATUS_ABSENT;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = root_child;
                     ptr_in          = root_child;
                     rem_in          = rem_ff - 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (total_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ql0_in = root0_ff;
                     ql1_in = root1_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_WALK: begin
            mem_req.wr_en       = 1'b1;
            mem_req.wr_addr     = ptr_ff;
            mem_req.wr_data     = rd_data;
            mem_req.wr_data.cnt = rd_data.cnt + 1'b1;
            if (leaf) begin
               total_in = total_ff + 1'b1;
            end else begin
               rem_in = rem_ff - 1'b1;
               if (node_child == '0) begin
                  if (pick_bit) mem_req.wr_data.link1 = free_ptr;
                  else          mem_req.wr_data.link0 = free_ptr;
                  ptr_in  = free_ptr;
                  free_in = free_ff + 1'b1;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = node_child;
                  ptr_in          = node_child;
               end
            end
         end
         ST_INS_NEW: begin
            mem_req.wr_en       = 1'b1;
            mem_req.wr_addr     = ptr_ff;
            mem_req.wr_data.cnt = COUNT_BITS'(1);
            if (leaf) begin
               total_in = total_ff + 1'b1;
            end else begin
               if (pick_bit) mem_req.wr_data.link1 = free_ptr;
               else          mem_req.wr_data.link0 = free_ptr;
               ptr_in  = free_ptr;
               free_in = free_ff + 1'b1;
               rem_in  = rem_ff - 1'b1;
            end
         end
         ST_ERS_CHECK: begin
            if (rd_data.cnt == '0 || (!leaf && node_child == '0)) begin
               status_in = STATUS_ABSENT;
            end else if (leaf) begin
               rem_in = LVL_W'(KEY_BITS);
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = node_child;
               ptr_in          = node_child;
               rem_in          = rem_ff - 1'b1;
            end
         end
         ST_ERS_ROOT: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = root_child;
            ptr_in          = root_child;
            rem_in          = rem_ff - 1'b1;
         end
         ST_ERS_DEC: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff;
            mem_req.wr_data = rd_data;
            if (rd_data.cnt != '0) mem_req.wr_data.cnt = rd_data.cnt - 1'b1;
            if (leaf) begin
               if (total_ff != '0) total_in = total_ff - 1'b1;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = node_child;
               ptr_in          = node_child;
               rem_in          = rem_ff - 1'b1;
            end
         end
         ST_QRY_PICK: begin
            if (!leaf) begin
               if (q_opp != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = q_opp;
               end else if (q_same != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = q_same;
               end else begin
                  rem_in = rem_ff - 1'b1;
               end
            end
         end
         ST_QRY_OPP: begin
            if (rd_data.cnt != '0) begin
               ans_in[pick_idx] = 1'b1;
               ql0_in           = rd_data.link0;
               ql1_in           = rd_data.link1;
               rem_in           = rem_ff - 1'b1;
            end else if (q_same != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = q_same;
            end else begin
               rem_in = rem_ff - 1'b1;
            end
         end
         ST_QRY_SAME: begin
            if (rd_data.cnt != '0) begin
               ql0_in = rd_data.link0;
               ql1_in = rd_data.link1;
            end
            rem_in = rem_ff - 1'b1;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ans_ff;
               rsp_status_in = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= FREE_W'(1);
         total_ff     <= '0;
         root0_ff     <= '0;
         root1_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         root0_ff     <= root0_in;
         root1_ff     <= root1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      rem_ff        <= rem_in;
      ptr_ff        <= ptr_in;
      ql0_ff        <= ql0_in;
      ql1_ff        <= ql1_in;
      ans_ff        <= ans_in;
      status_ff     <= status_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   // pool never overruns
   assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_W'(NODE_COUNT))
      else $error("node pool index beyond pool size");

   // slot zero is the null link and is never written
   assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (mem_req.wr_addr != '0))
      else $error("write to null node slot");

   // no read of the entry being written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("node read and write collide");

   // a finished transaction reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished transaction not presented");

endmodule

// ===== sv/btm_node_mem.sv =====
// ----------------------------------------------------------------------------
// btm_node_mem
// trie node pool: one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module btm_node_mem (
   input  logic                 clock,
   input  btm_pkg::mem_req_type mem_req,
   output btm_pkg::node_type    rd_data
);
   import btm_pkg::*;

   node_type mem_ff [NODE_COUNT];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/trie_xor_checker.sv =====
// ----------------------------------------------------------------------------
// trie_xor_checker
// watches the req and rsp channels of the trie multiset, keeps its own trie,
// predicts answer and status of every request transaction and compares each
// rsp transaction field by field with the oldest prediction
// ----------------------------------------------------------------------------
module trie_xor_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [btm_pkg::VALUE_W-1:0]   req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [btm_pkg::ANSWER_W-1:0]  rsp_answer,
   input  logic [1:0]                    rsp_status,
   output int                            mismatches,
   output int                            awaited
);

   import btm_pkg::*;

   typedef struct packed {
      logic [ANSWER_W-1:0] answer;
      logic [1:0]          status;
   } outcome_type;

   // slot 0 never holds a node, so its links serve as the root links
   logic [PTR_W-1:0]      kid [0:1][0:NODE_COUNT-1];
   logic [COUNT_BITS-1:0] tally [0:NODE_COUNT-1];
   int unsigned           free_slot;
   logic [COUNT_BITS-1:0] members;
   outcome_type           due_outcomes [$];

   function automatic void enqueue_outcome(input outcome_type res);
      due_outcomes.insert(due_outcomes.size(), res);
   endfunction

   task automatic apply_to_trie(input logic [1:0] op, input logic [VALUE_W-1:0] key,
                                output outcome_type res);
      logic [PTR_W-1:0] cur;
      logic [PTR_W-1:0] nxt;
      logic             found;
      res   = '0;
      cur   = '0;
      found = 1'b1;
      case (op)
         OP_INSERT: begin
            if (free_slot + KEY_BITS > NODE_COUNT || members == '1) begin
               res.status = STATUS_NO_ROOM;
            end else begin
               for (int i = KEY_BITS - 1; i >= 0; i--) begin
                  nxt = kid[key[i]][cur];
                  if (nxt == 0) begin
                     nxt = PTR_W'(free_slot);
                     free_slot++;
                     kid[0][nxt] = '0;
                     kid[1][nxt] = '0;
                     tally[nxt]  = '0;
                     kid[key[i]][cur] = nxt;
                  end
                  cur = nxt;
                  tally[cur]++;
               end
               members++;
            end
         end
         OP_ERASE: begin
            for (int i = KEY_BITS - 1; i >= 0; i--) begin
               nxt = kid[key[i]][cur];
               if (nxt == 0 || tally[nxt] == 0) begin
                  found = 1'b0;
                  break;
               end
               cur = nxt;
            end
            if (!found) begin
               res.status = STATUS_ABSENT;
            end else begin
               cur = '0;
               for (int i = KEY_BITS - 1; i >= 0; i--) begin
                  cur = kid[key[i]][cur];
                  tally[cur]--;
               end
               members--;
            end
         end
         OP_QUERY: begin
            if (members == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               // prefer the opposite bit, fall back to the same bit
               for (int i = KEY_BITS - 1; i >= 0; i--) begin
                  nxt = kid[~key[i]][cur];
                  if (nxt != 0 && tally[nxt] != 0) begin
                     res.answer[i] = 1'b1;
                     cur = nxt;
                  end else begin
                     nxt = kid[key[i]][cur];
                     if (nxt != 0 && tally[nxt] != 0)
                        cur = nxt;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      outcome_type want;
      outcome_type got;
      if (reset) begin
         due_outcomes.delete();
         kid[0][0]  = '0;
         kid[1][0]  = '0;
         free_slot  = 1;
         members    = '0;
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_answer, rsp_status};
            if (due_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transaction, expected none, got answer %h status %0d",
                        $time, got.answer, got.status);
            end else begin
               want = due_outcomes.pop_front();
               if (got.answer !== want.answer) begin
                  mismatches++;
                  $display("%0t: answer expected %h got %h", $time, want.answer, got.answer);
               end
               if (got.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_to_trie(req_op, req_value, want);
            enqueue_outcome(want);
         end
      end
      awaited = due_outcomes.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives insert, erase and query transactions into the trie multiset: a
// directed run over the corner cases, then random runs built on families of
// keys with shared prefixes and random idling on both sides, ending with a run
// that fills the node pool; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;

   import btm_pkg::*;

   localparam int         LIMIT       = 24_000_000;
   localparam int         FAMILY_SIZE = 40;
   localparam logic [1:0] OP_UNKNOWN  = 2'd3;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_op    = OP_INSERT;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ANSWER_W-1:0] rsp_answer;
   logic [1:0]          rsp_status;
   int                  mismatches;
   int                  awaited;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   logic [VALUE_W-1:0]  family [0:FAMILY_SIZE-1];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   binary_trie_max_xor_multiset dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_answer (rsp_answer),
      .rsp_status (rsp_status)
   );

   trie_xor_checker trie_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_answer (rsp_answer),
      .rsp_status (rsp_status),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // entered and left at a falling edge
   task automatic send_item(input logic [1:0] op, input logic [VALUE_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited != 0) @(negedge clock);
   endtask

   task automatic run_random(input int items, input int insert_pct, input int fresh_pct);
      int                 dice;
      logic [VALUE_W-1:0] key;
      for (int n = 0; n < items; n++) begin
         dice = $urandom_range(99);
         key  = family[$urandom_range(FAMILY_SIZE - 1)];
         if ($urandom_range(99) == 0)
            drain();
         if (dice < insert_pct) begin
            if ($urandom_range(99) < fresh_pct)
               key = VALUE_W'($urandom);
            send_item(OP_INSERT, key);
         end else if (dice < insert_pct + 30) begin
            case ($urandom_range(9))
               0:       key = VALUE_W'($urandom);
               1:       key = key ^ (31'd1 << $urandom_range(KEY_BITS - 1));
               default: ;
            endcase
            send_item(OP_ERASE, key);
         end else if (dice < 97) begin
            if ($urandom_range(1) == 0)
               key = VALUE_W'($urandom);
            else
               key = key ^ VALUE_W'($urandom & ((32'd1 << $urandom_range(KEY_BITS - 1)) - 1));
            send_item(OP_QUERY, key);
         end else begin
            send_item(OP_UNKNOWN, VALUE_W'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      logic [VALUE_W-1:0] chain;
      chain = '0;
      // chains of keys that share long prefixes
      for (int k = 0; k < FAMILY_SIZE; k++) begin
         if (k % 5 == 0)
            chain = VALUE_W'($urandom);
         else
            chain = chain ^ VALUE_W'($urandom &
                                     ((32'd1 << $urandom_range(KEY_BITS - 1, 1)) - 1));
         family[k] = chain;
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(OP_QUERY,   31'd0);
      send_item(OP_ERASE,   31'd5);
      send_item(OP_UNKNOWN, 31'h7fffffff);
      send_item(OP_INSERT,  31'd0);
      send_item(OP_INSERT,  31'h7fffffff);
      send_item(OP_INSERT,  31'h7fffffff);
      send_item(OP_QUERY,   31'd0);
      send_item(OP_QUERY,   31'h7fffffff);
      send_item(OP_QUERY,   31'h55555555);
      send_item(OP_ERASE,   31'h7fffffff);
      send_item(OP_QUERY,   31'd0);
      send_item(OP_ERASE,   31'h7fffffff);
      // path exists but its counts are back to zero
      send_item(OP_ERASE,   31'h7fffffff);
      send_item(OP_QUERY,   31'd0);
      send_item(OP_ERASE,   31'd0);
      send_item(OP_QUERY,   31'd12345);
      send_item(OP_ERASE,   31'd0);
      send_item(OP_INSERT,  31'h2aaaaaaa);
      send_item(OP_INSERT,  31'h2aaaaaab);
      send_item(OP_QUERY,   31'd1);
      send_item(OP_UNKNOWN, 31'd0);
      drain();

      send_idle_pct = 31;
      recv_idle_pct = 69;
      run_random(700, 40, 8);
      drain();

      send_idle_pct = 69;
      recv_idle_pct = 31;
      run_random(700, 40, 8);
      drain();

      // mostly fresh keys, so the node pool runs out along the way
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(600, 60, 90);
      drain();

      repeat (120) @(negedge clock);
      if (mismatches == 0)
         $display("binary_trie_max_xor_multiset: match");
      else
         $display("binary_trie_max_xor_multiset: mismatch");
      $finish;
   end

   initial begin
      #LIMIT;
      $display("binary_trie_max_xor_multiset: mismatch");
      $finish;
   end

endmodule
